FILE: sv/mups_pkg.sv
`timescale 1ns / 1ps

package mups_pkg;

	// Default widths and counts
	localparam int QUANTITY_COUNT_DEF = 4;
	localparam int TIMER_WIDTH_DEF    = 16;
	localparam int LEFT_W             = 3;
	localparam int PERIOD_W           = 16;
	localparam int RETRY_W            = 3;
	localparam int ADDR_W             = 5;
	localparam int DATA_W             = 32;

	// Reading format
	localparam logic [23:0] SIGN_BIT  = 24'h80_0000;
	localparam logic [23:0] MAG_MASK  = 24'h7F_FFFF;
	localparam logic [7:0]  BYTE_MASK = 8'hFF;
	localparam logic [1:0]  SLOT_POWER = 2'd2;

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_AUTO_ENABLE   = 3'd0;
	localparam logic [2:0] REG_POLL_PERIOD   = 3'd1;
	localparam logic [2:0] REG_TIMEOUT_TICKS = 3'd2;
	localparam logic [2:0] REG_MAX_RETRIES   = 3'd3;
	localparam logic [2:0] REG_READ_COMMAND  = 3'd4;
	localparam logic [2:0] REG_QTY_ADDRESSES = 3'd5;

	// Register reset values
	localparam logic                RST_AUTO_ENABLE   = 1'b1;
	localparam logic [PERIOD_W-1:0] RST_POLL_PERIOD   = 16'd1000;
	localparam logic [PERIOD_W-1:0] RST_TIMEOUT_TICKS = 16'd200;
	localparam logic [RETRY_W-1:0]  RST_MAX_RETRIES   = 3'd5;
	localparam logic [7:0]          RST_READ_COMMAND  = 8'd88;
	localparam logic [31:0]         RST_QTY_ADDRESSES = 32'd117834755;

	typedef struct packed {
		logic                auto_enable;
		logic [PERIOD_W-1:0] poll_period;
		logic [PERIOD_W-1:0] timeout_ticks;
		logic [RETRY_W-1:0]  max_retries;
		logic [7:0]          read_command;
		logic [31:0]         quantity_addresses;
	} cfg_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_command;
		logic [7:0]  tx_address;
		logic        meas_valid;
		logic [1:0]  meas_slot;
		logic [23:0] meas_value;
		logic        checksum_error;
		logic        gave_up;
	} res_t;

	// Address byte of a measurement slot: voltage, current, power, energy
	function automatic logic [7:0] slot_address(input logic [1:0] slot,
			input logic [31:0] addrs);
		logic [7:0] a;
		case (slot)
			2'd0:    a = addrs[15:8];
			2'd1:    a = addrs[7:0];
			2'd2:    a = addrs[23:16];
			2'd3:    a = addrs[31:24];
			default: a = addrs[7:0];
		endcase
		return a;
	endfunction

	// Slot for queue position k (1..4): current, voltage, power, energy
	function automatic logic [1:0] queue_slot(input logic [LEFT_W-1:0] k);
		logic [1:0] pos;
		logic [1:0] s;
		pos = 2'(k - 3'd1);
		case (pos)
			2'd0:    s = 2'd1;
			2'd1:    s = 2'd0;
			2'd2:    s = 2'd2;
			2'd3:    s = 2'd3;
			default: s = 2'd1;
		endcase
		return s;
	endfunction

endpackage

FILE: sv/mups_in_if.sv
`timescale 1ns / 1ps

interface mups_in_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] rx_byte0;
	logic [7:0] rx_byte1;
	logic [7:0] rx_byte2;
	logic [7:0] rx_check;

	modport source (output valid, action, rx_byte0, rx_byte1, rx_byte2, rx_check,
		input ready);
	modport sink (input valid, action, rx_byte0, rx_byte1, rx_byte2, rx_check,
		output ready);
endinterface

FILE: sv/mups_out_if.sv
`timescale 1ns / 1ps

interface mups_out_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_command;
	logic [7:0]  tx_address;
	logic        meas_valid;
	logic [1:0]  meas_slot;
	logic [23:0] meas_value;
	logic        checksum_error;
	logic        gave_up;

	modport source (output valid, tx_valid, tx_command, tx_address, meas_valid,
		meas_slot, meas_value, checksum_error, gave_up, input ready);
	modport sink (input valid, tx_valid, tx_command, tx_address, meas_valid,
		meas_slot, meas_value, checksum_error, gave_up, output ready);
endinterface

FILE: sv/mups_cfg_regs.sv
`timescale 1ns / 1ps

module mups_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mups_pkg::ADDR_W-1:0] paddr,
	input  logic [mups_pkg::DATA_W-1:0] pwdata,
	output logic [mups_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output mups_pkg::cfg_t              cfg
);
	import mups_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_enable        <= RST_AUTO_ENABLE;
			cfg_q.poll_period        <= RST_POLL_PERIOD;
			cfg_q.timeout_ticks      <= RST_TIMEOUT_TICKS;
			cfg_q.max_retries        <= RST_MAX_RETRIES;
			cfg_q.read_command       <= RST_READ_COMMAND;
			cfg_q.quantity_addresses <= RST_QTY_ADDRESSES;
		end else if (wr_en) begin
			case (idx)
				REG_AUTO_ENABLE:   cfg_q.auto_enable        <= pwdata[0];
				REG_POLL_PERIOD:   cfg_q.poll_period        <= pwdata[PERIOD_W-1:0];
				REG_TIMEOUT_TICKS: cfg_q.timeout_ticks      <= pwdata[PERIOD_W-1:0];
				REG_MAX_RETRIES:   cfg_q.max_retries        <= pwdata[RETRY_W-1:0];
				REG_READ_COMMAND:  cfg_q.read_command       <= pwdata[7:0];
				REG_QTY_ADDRESSES: cfg_q.quantity_addresses <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			REG_AUTO_ENABLE:   prdata = DATA_W'(cfg_q.auto_enable);
			REG_POLL_PERIOD:   prdata = DATA_W'(cfg_q.poll_period);
			REG_TIMEOUT_TICKS: prdata = DATA_W'(cfg_q.timeout_ticks);
			REG_MAX_RETRIES:   prdata = DATA_W'(cfg_q.max_retries);
			REG_READ_COMMAND:  prdata = DATA_W'(cfg_q.read_command);
			REG_QTY_ADDRESSES: prdata = cfg_q.quantity_addresses;
			default:           prdata = '0;
		endcase
	end

endmodule

FILE: sv/mups_engine.sv
`timescale 1ns / 1ps

module mups_engine #(
	parameter int QUANTITY_COUNT = mups_pkg::QUANTITY_COUNT_DEF,
	parameter int TIMER_WIDTH    = mups_pkg::TIMER_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mups_pkg::cfg_t    cfg,
	mups_in_if.sink           req,
	mups_out_if.source        rsp
);
	import mups_pkg::*;

	localparam int CW = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;
	localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

	// Input stage
	logic       valid_s1;
	logic       action_s1;
	logic [7:0] b0_s1, b1_s1, b2_s1, chk_s1;

	// Sequencer state
	logic                   pending_q, pending_n;
	logic [1:0]             slot_q, slot_n;
	logic                   armed_q, armed_n;
	logic [TIMER_WIDTH-1:0] to_q, to_n, to_inc;
	logic [TIMER_WIDTH-1:0] poll_q, poll_n, poll_inc;
	logic [LEFT_W-1:0]      left_q, left_n, k;
	logic [RETRY_W-1:0]     retry_q, retry_n;

	// Output register
	logic out_valid_q;
	res_t res_q, res;

	logic        fire;
	logic        timed_out, fail, skip_issue;
	logic [7:0]  cur_addr, sum8;
	logic [23:0] data;
	logic [1:0]  new_slot;

	assign fire      = valid_s1 & (~out_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			b0_s1     <= req.rx_byte0;
			b1_s1     <= req.rx_byte1;
			b2_s1     <= req.rx_byte2;
			chk_s1    <= req.rx_check;
		end
	end

	// One step of the poll sequencer
	always_comb begin
		pending_n  = pending_q;
		slot_n     = slot_q;
		armed_n    = armed_q;
		to_n       = to_q;
		poll_n     = poll_q;
		left_n     = left_q;
		retry_n    = retry_q;
		res        = '0;
		timed_out  = 1'b0;
		fail       = 1'b0;
		skip_issue = 1'b0;

		to_inc   = (to_q == TMAX) ? to_q : to_q + 1'b1;
		poll_inc = (poll_q == TMAX) ? poll_q : poll_q + 1'b1;
		cur_addr = slot_address(slot_q, cfg.quantity_addresses);
		sum8     = cfg.read_command + cur_addr + b0_s1 + b1_s1 + b2_s1;
		data     = {b2_s1, b1_s1, b0_s1};
		if (slot_q == SLOT_POWER) begin
			if ((data & SIGN_BIT) != '0) begin
				data = ((~data) & MAG_MASK) + 24'd1;
			end else begin
				data = data & MAG_MASK;
			end
		end

		if (!action_s1) begin
			// Timer tick: reply timeout and poll period
			if (armed_q) begin
				to_n = to_inc;
				if (CW'(to_inc) >= CW'(cfg.timeout_ticks)) begin
					to_n      = '0;
					armed_n   = 1'b0;
					timed_out = 1'b1;
				end
			end else begin
				to_n = '0;
			end
			if (cfg.auto_enable) begin
				poll_n = poll_inc;
				if (CW'(poll_inc) >= CW'(cfg.poll_period)) begin
					poll_n = '0;
					left_n = LEFT_W'(QUANTITY_COUNT);
				end
			end else begin
				poll_n = '0;
			end
			fail = timed_out & pending_q;
		end else if (!pending_q) begin
			// Unsolicited frame: dropped
			skip_issue = 1'b1;
		end else if (chk_s1 == (BYTE_MASK ^ sum8)) begin
			res.meas_valid = 1'b1;
			res.meas_slot  = slot_q;
			res.meas_value = data;
			pending_n      = 1'b0;
			armed_n        = 1'b0;
			to_n           = '0;
			retry_n        = '0;
		end else begin
			res.checksum_error = 1'b1;
			fail               = 1'b1;
		end

		// Re-send or abandon the pending read
		if (fail) begin
			if (retry_q < cfg.max_retries) begin
				retry_n        = retry_q + 3'd1;
				res.tx_valid   = 1'b1;
				res.tx_command = cfg.read_command;
				res.tx_address = cur_addr;
				armed_n        = 1'b1;
				to_n           = '0;
			end else begin
				pending_n   = 1'b0;
				armed_n     = 1'b0;
				to_n        = '0;
				retry_n     = '0;
				res.gave_up = 1'b1;
			end
		end

		// Issue the next queued read
		k        = (left_n > 3'd4) ? 3'd4 : left_n;
		new_slot = queue_slot(k);
		if (!skip_issue && !pending_n && left_n != '0 && !res.tx_valid) begin
			slot_n         = new_slot;
			left_n         = k - 3'd1;
			pending_n      = 1'b1;
			retry_n        = '0;
			res.tx_valid   = 1'b1;
			res.tx_command = cfg.read_command;
			res.tx_address = slot_address(new_slot, cfg.quantity_addresses);
			armed_n        = 1'b1;
			to_n           = '0;
		end
	end

	// State and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			slot_q      <= '0;
			armed_q     <= 1'b0;
			to_q        <= '0;
			poll_q      <= '0;
			left_q      <= '0;
			retry_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				pending_q <= pending_n;
				slot_q    <= slot_n;
				armed_q   <= armed_n;
				to_q      <= to_n;
				poll_q    <= poll_n;
				left_q    <= left_n;
				retry_q   <= retry_n;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.tx_valid       = res_q.tx_valid;
	assign rsp.tx_command     = res_q.tx_command;
	assign rsp.tx_address     = res_q.tx_address;
	assign rsp.meas_valid     = res_q.meas_valid;
	assign rsp.meas_slot      = res_q.meas_slot;
	assign rsp.meas_value     = res_q.meas_value;
	assign rsp.checksum_error = res_q.checksum_error;
	assign rsp.gave_up        = res_q.gave_up;

endmodule

FILE: sv/meter_uart_poll_sequencer_unit.sv
`timescale 1ns / 1ps

// Energy-meter register poll sequencer.
// req carries one event per transaction: a timer tick (action 0) or a received
// reply frame (action 1, three data bytes and a check byte). rsp returns exactly
// one result transaction per req transaction: a read command to send (tx_*),
// a verified reading (meas_*), and checksum_error / gave_up flags.
// The req transaction is taken into the input register and its result is then
// loaded into the result register, which drives rsp.valid; a result that waits
// on rsp.ready holds the transaction in the input register.
// Throughput: one transaction per cycle while rsp.ready is high or the result
// register is empty; the next-state logic of the sequencer is combinational.
// The APB port holds the six configuration registers at byte addresses 4*i;
// write them only while no transaction is in flight.
// Reset (arst_n low) clears the sequencer state and both pipeline stages and
// loads the register defaults; polling starts after poll_period ticks.
// When rsp.ready is low the result is held; req.ready stays high until the
// input register also fills, so nothing is lost or repeated.
module meter_uart_poll_sequencer_unit #(
	parameter int QUANTITY_COUNT = mups_pkg::QUANTITY_COUNT_DEF,
	parameter int TIMER_WIDTH    = mups_pkg::TIMER_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mups_in_if.sink                     req,
	mups_out_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mups_pkg::ADDR_W-1:0] paddr,
	input  logic [mups_pkg::DATA_W-1:0] pwdata,
	output logic [mups_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import mups_pkg::*;

	cfg_t cfg;

	mups_cfg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mups_engine #(
		.QUANTITY_COUNT (QUANTITY_COUNT),
		.TIMER_WIDTH    (TIMER_WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.rsp    (rsp)
	);

	// A frame that publishes a reading neither failed its check nor was abandoned
	a_meas_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.meas_valid |-> !rsp.checksum_error && !rsp.gave_up)
		else $error("reading published with an error flag");

	// Command frames always carry the configured read command
	a_tx_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.tx_valid |-> rsp.tx_command == cfg.read_command)
		else $error("command byte differs from read_command");

	// Unused fields are zero
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.tx_valid |-> rsp.tx_command == 8'd0 && rsp.tx_address == 8'd0)
		else $error("command fields set without tx_valid");

	a_meas_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.meas_valid |-> rsp.meas_slot == 2'd0 && rsp.meas_value == 24'd0)
		else $error("measurement fields set without meas_valid");

endmodule
